FILE: sv/variable_bit_crc8_crc16_top_defines.svh
// assertion macros for the variable bit crc8/crc16 block
// expects clk and rst_n in the scope of each use
`ifndef VARIABLE_BIT_CRC8_CRC16_TOP_DEFINES_SVH
`define VARIABLE_BIT_CRC8_CRC16_TOP_DEFINES_SVH

// same-cycle implication
`define VBCRC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VBCRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/vbcrc_pkg.sv
// package for the variable bit crc8/crc16 block
// field widths, register map, polynomials and the bit fold function
package vbcrc_pkg;

    localparam int DATA_W  = 16;
    localparam int COUNT_W = 5;
    localparam int CRC_W   = 16;
    localparam int ADDR_W  = 3;
    localparam int PDATA_W = 32;

    localparam logic [15:0] POLY_WIDE   = 16'hBAAD;
    localparam logic [7:0]  POLY_NARROW = 8'h97;

    // register index, taken from paddr[2]
    localparam logic REG_MODE = 1'b0;

    typedef enum logic
    {
        MODE_CRC8  = 1'b0,
        MODE_CRC16 = 1'b1
    } crc_mode_t;

    typedef logic [DATA_W-1:0]  data_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [CRC_W-1:0]   crc_t;

    // fold the low count bits of data into crc, msb first
    function automatic crc_t crc_fold(input crc_t crc_in, input data_t data,
                                      input count_t count, input crc_mode_t mode);
        crc_t crc;
        crc_t poly;
        logic msb;
        poly = (mode == MODE_CRC16) ? POLY_WIDE : {8'h00, POLY_NARROW};
        crc  = (mode == MODE_CRC16) ? crc_in : {8'h00, crc_in[7:0]};
        for (int j = DATA_W - 1; j >= 0; j--)
        begin
            if (COUNT_W'(j) < count)
            begin
                msb = (mode == MODE_CRC16) ? crc[15] : crc[7];
                crc = {crc[14:0], 1'b0};
                if (mode == MODE_CRC8)
                begin
                    crc[15:8] = 8'h00;
                end
                if (data[j] != msb)
                begin
                    crc = crc ^ poly;
                end
            end
        end
        return crc;
    endfunction

endpackage

FILE: sv/vbcrc_if.sv
// item channels of the variable bit crc8/crc16 block
// depends on vbcrc_pkg
interface vbcrc_in_if;
    import vbcrc_pkg::*;

    logic   valid;
    logic   ready;
    data_t  data_bits;
    count_t bit_count;
    logic   start_new;

    modport source (output valid, data_bits, bit_count, start_new, input ready);
    modport sink   (input valid, data_bits, bit_count, start_new, output ready);
endinterface

interface vbcrc_out_if;
    import vbcrc_pkg::*;

    logic valid;
    logic ready;
    crc_t crc_out;

    modport source (output valid, crc_out, input ready);
    modport sink   (input valid, crc_out, output ready);
endinterface

FILE: sv/variable_bit_crc8_crc16_top.sv
// top level of the variable bit crc8/crc16 block
// depends on vbcrc_pkg, vbcrc_if.sv and variable_bit_crc8_crc16_top_defines.svh
//
// usage
//   item_in carries data_bits, bit_count and start_new; each item folds its low
//   bit_count data bits (msb first) into a running crc, after clearing it
//   when start_new is set. crc_result returns one item per input item with
//   the updated crc (upper byte zero in 8-bit mode).
//   the apb port holds one register at address 0: crc width mode,
//   0 for crc8 poly 0x97, 1 for crc16 poly 0xBAAD (reset value).
//   an accepted item passes from the input register to the result register;
//   one item per cycle sustained unless the receiver stalls. the whole fold is
//   combinational between them; the running crc updates with the result register.
//   reset clears the running crc to zero, sets crc16 mode and empties both
//   registers. when the receiver stalls, the result register holds, the
//   input register fills and item_in.ready drops until the result is taken.
`include "variable_bit_crc8_crc16_top_defines.svh"

module variable_bit_crc8_crc16_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vbcrc_pkg::ADDR_W-1:0]  paddr,
    input  logic [vbcrc_pkg::PDATA_W-1:0] pwdata,
    output logic [vbcrc_pkg::PDATA_W-1:0] prdata,
    output logic                          pready,
    vbcrc_in_if.sink                      item_in,
    vbcrc_out_if.source                   crc_result
);
    import vbcrc_pkg::*;

    crc_mode_t mode_reg;
    logic      s1_valid_reg;
    data_t     s1_data_reg;
    count_t    s1_count_reg;
    logic      s1_start_reg;
    crc_t      crc_reg;
    crc_t      crc_next;
    logic      out_valid_reg;
    crc_t      out_crc_reg;
    logic      s1_advance;
    logic      in_accept;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MODE) ? {{(PDATA_W-1){1'b0}}, mode_reg}
                                           : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_CRC16;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_MODE)
        begin
            mode_reg <= crc_mode_t'(pwdata[0]);
        end
    end

    // handshakes
    assign s1_advance       = s1_valid_reg && (!out_valid_reg || crc_result.ready);
    assign item_in.ready    = !s1_valid_reg || s1_advance;
    assign in_accept        = item_in.valid && item_in.ready;
    assign crc_result.valid = out_valid_reg;
    assign crc_result.crc_out = out_crc_reg;

    // fold
    always_comb
    begin
        crc_next = crc_fold(s1_start_reg ? '0 : crc_reg, s1_data_reg, s1_count_reg,
                            mode_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            crc_reg       <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
                crc_reg       <= crc_next;
            end
            else if (crc_result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_data_reg  <= item_in.data_bits;
            s1_count_reg <= item_in.bit_count;
            s1_start_reg <= item_in.start_new;
        end
        if (s1_advance)
        begin
            out_crc_reg <= crc_next;
        end
    end

    `VBCRC_ASSERT_NEXT(a_result_tracks_state, s1_advance, out_crc_reg == crc_reg,
                       "result register differs from running crc")
    `VBCRC_ASSERT_NOW(a_no_input_overrun, in_accept, !s1_valid_reg || s1_advance,
                      "item accepted over a held item")
    `VBCRC_ASSERT_NEXT(a_start_empty_clears, s1_advance && s1_start_reg && s1_count_reg == '0,
                       crc_reg == '0, "start with no bits left crc non-zero")

endmodule
